>>> design/u8vd_pkg.sv
`default_nettype none
package u8vd_pkg;

    localparam int unsigned CpWidth = 21;

    // status codes
    localparam logic [2:0] StOk         = 3'd0;
    localparam logic [2:0] StBadLead    = 3'd1;
    localparam logic [2:0] StBadCont    = 3'd2;
    localparam logic [2:0] StIncomplete = 3'd3;
    localparam logic [2:0] StHalted     = 3'd4;

    // first continuation byte ranges
    localparam logic [2:0] RuleGeneric = 3'd0; // 80..bf
    localparam logic [2:0] RuleE0      = 3'd1; // a0..bf
    localparam logic [2:0] RuleEd      = 3'd2; // 80..9f
    localparam logic [2:0] RuleF0      = 3'd3; // 90..bf
    localparam logic [2:0] RuleF4      = 3'd4; // 80..8f

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] bytes_after;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               complete;
        logic [2:0]         status;
    } t_out;

    typedef struct packed {
        logic [1:0]         pending_count;
        logic [2:0]         first_cont_rule;
        logic               first_cont_due;
        logic [CpWidth-1:0] accum;
        logic               halted;
    } t_state;

endpackage
`default_nettype wire

>>> design/u8vd_step.sv
`default_nettype none
module u8vd_step (
    input  var u8vd_pkg::t_in    i_item,
    input  var u8vd_pkg::t_state i_state,
    output u8vd_pkg::t_out       o_result,
    output u8vd_pkg::t_state     o_state
);

    logic [7:0]                      b;
    logic                            first_ok;
    logic                            cont_ok;
    logic [1:0]                      need;
    logic [2:0]                      rule;
    logic [u8vd_pkg::CpWidth-1:0]    bits;
    logic                            bad;
    logic [u8vd_pkg::CpWidth-1:0]    shifted;
    u8vd_pkg::t_state                cur;
    u8vd_pkg::t_state                nxt;
    u8vd_pkg::t_out                  res;

    assign b = i_item.data_byte;

    always_comb begin
        case (i_state.first_cont_rule)
            u8vd_pkg::RuleE0: first_ok = b inside {[8'hA0:8'hBF]};
            u8vd_pkg::RuleEd: first_ok = b inside {[8'h80:8'h9F]};
            u8vd_pkg::RuleF0: first_ok = b inside {[8'h90:8'hBF]};
            u8vd_pkg::RuleF4: first_ok = b inside {[8'h80:8'h8F]};
            default:          first_ok = b inside {[8'h80:8'hBF]};
        endcase
    end

    // lead byte classification
    always_comb begin
        need = 2'd0;
        rule = u8vd_pkg::RuleGeneric;
        bits = '0;
        bad  = 1'b0;
        if (b inside {[8'h00:8'h7F]}) begin
            bits = {{(u8vd_pkg::CpWidth-8){1'b0}}, b};
        end else if (b inside {[8'hC2:8'hDF]}) begin
            need = 2'd1;
            bits = {{(u8vd_pkg::CpWidth-5){1'b0}}, b[4:0]};
        end else if (b inside {[8'hE0:8'hEF]}) begin
            need = 2'd2;
            bits = {{(u8vd_pkg::CpWidth-4){1'b0}}, b[3:0]};
            if (b == 8'hE0) begin
                rule = u8vd_pkg::RuleE0;
            end else if (b == 8'hED) begin
                rule = u8vd_pkg::RuleEd;
            end
        end else if (b inside {[8'hF0:8'hF4]}) begin
            need = 2'd3;
            bits = {{(u8vd_pkg::CpWidth-3){1'b0}}, b[2:0]};
            if (b == 8'hF0) begin
                rule = u8vd_pkg::RuleF0;
            end else if (b == 8'hF4) begin
                rule = u8vd_pkg::RuleF4;
            end
        end else begin
            bad = 1'b1;
        end
    end

    always_comb begin
        cur = i_state;
        if (i_item.restart) begin
            cur = '0;
        end
        cont_ok = cur.first_cont_due ? first_ok : (b[7:6] == 2'b10);
        shifted = {cur.accum[u8vd_pkg::CpWidth-7:0], b[5:0]};

        nxt = cur;
        res = '0;
        res.status = u8vd_pkg::StOk;

        if (cur.halted) begin
            res.status = u8vd_pkg::StHalted;
        end else if (cur.pending_count == 2'd0) begin
            if (bad) begin
                res.status = u8vd_pkg::StBadLead;
                nxt        = '0;
                nxt.halted = 1'b1;
            end else if (need == 2'd0) begin
                res.code_point = bits;
                res.complete   = 1'b1;
            end else if (i_item.bytes_after < need) begin
                res.status = u8vd_pkg::StIncomplete;
                nxt        = '0;
                nxt.halted = 1'b1;
            end else begin
                nxt.pending_count   = need;
                nxt.first_cont_rule = rule;
                nxt.first_cont_due  = 1'b1;
                nxt.accum           = bits;
            end
        end else if (!cont_ok) begin
            res.status = u8vd_pkg::StBadCont;
            nxt        = '0;
            nxt.halted = 1'b1;
        end else if (cur.pending_count == 2'd1) begin
            res.code_point = shifted;
            res.complete   = 1'b1;
            nxt            = '0;
        end else begin
            nxt.accum          = shifted;
            nxt.first_cont_due = 1'b0;
            nxt.pending_count  = cur.pending_count - 2'd1;
        end
    end

    assign o_result = res;
    assign o_state  = nxt;

endmodule
`default_nettype wire

>>> design/utf8_validating_decoder.sv
// an input beat passes the input register, then the result register, to the output
// throughput: one byte per cycle unless the output stalls; input register, decode
//   logic and result register form the only path, so a byte may enter every cycle
// reset (i_rst_n low, synchronous): both stages empty, sequence state and halt cleared
`default_nettype none
module utf8_validating_decoder (
    input  var logic           i_clk,
    input  var logic           i_rst_n,
    input  var logic           i_in_valid,
    output logic               o_in_ready,
    input  var u8vd_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  var logic           i_out_ready,
    output u8vd_pkg::t_out     o_out_data
);

    logic             r_in_valid;
    u8vd_pkg::t_in    r_in;
    logic             r_out_valid;
    u8vd_pkg::t_out   r_out;
    u8vd_pkg::t_state r_state;
    u8vd_pkg::t_state n_state;
    u8vd_pkg::t_out   n_out;
    logic             out_free;
    logic             in_ready;

    u8vd_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in <= i_in_data;
        end
    end

    // state advances only when the byte moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> design/u8vd_checker.sv
`default_nettype none
module u8vd_checker (
    input  var logic           i_clk,
    input  var logic           i_rst_n,
    input  var logic           i_in_valid,
    input  var logic           o_in_ready,
    input  var u8vd_pkg::t_in  i_in_data,
    input  var logic           o_out_valid,
    input  var logic           i_out_ready,
    input  var u8vd_pkg::t_out o_out_data
);

    // a finished character is never flagged with an error
    a_complete_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.complete) |-> (o_out_data.status == u8vd_pkg::StOk))
        else $error("complete beat with nonzero status");

    // code point only shown with complete
    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.complete) |-> (o_out_data.code_point == '0))
        else $error("code point without complete");

    // strict decode never yields a surrogate or out of range value
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.complete) |->
            (o_out_data.code_point <= 21'h10FFFF) &&
            !((o_out_data.code_point >= 21'h00D800) && (o_out_data.code_point <= 21'h00DFFF)))
        else $error("decoded value is not a scalar value");

    // an error status is followed by halted until a restart byte gets through
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_data.restart) ##2
            (o_out_valid && $past(o_out_valid) && $past(i_out_ready) &&
             ($past(o_out_data.status) != u8vd_pkg::StOk)) |->
            (o_out_data.status == u8vd_pkg::StHalted))
        else $error("byte after error not reported halted");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed while stalled");

endmodule

bind utf8_validating_decoder u8vd_checker u_u8vd_checker (.*);
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    u8vd_pkg::t_in  i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    u8vd_pkg::t_out o_out_data;

    utf8_validating_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    u8vd_pkg::t_in  byte_q[$];
    u8vd_pkg::t_out char_exp_q[$];
    int   n_in_beats = 0;
    int   n_errors = 0;
    logic in_beat_taken = 1'b0;
    logic out_hold = 1'b0;
    logic calm;

    // decoder state mirrored in the testbench
    logic [1:0]  dec_pend = '0;
    logic [2:0]  dec_rule = u8vd_pkg::RuleGeneric;
    logic        dec_first = 1'b0;
    logic [20:0] dec_acc = '0;
    logic        dec_halted = 1'b0;

    // no random idling on either side for a stretch of the run
    assign calm = (n_in_beats >= 120) && (n_in_beats < 220);

    function automatic void drop_partial();
        dec_pend  = '0;
        dec_rule  = u8vd_pkg::RuleGeneric;
        dec_first = 1'b0;
        dec_acc   = '0;
    endfunction

    function automatic u8vd_pkg::t_out decode_byte(u8vd_pkg::t_in b);
        u8vd_pkg::t_out r;
        logic [7:0]     d;
        logic [1:0]     need;
        logic [2:0]     rl;
        logic [20:0]    bits;
        logic           bad;
        logic           ok;
        r    = '0;
        d    = b.data_byte;
        need = '0;
        rl   = u8vd_pkg::RuleGeneric;
        bits = '0;
        bad  = 1'b0;
        r.status = u8vd_pkg::StOk;
        if (b.restart) begin
            drop_partial();
            dec_halted = 1'b0;
        end
        if (dec_halted) begin
            r.status = u8vd_pkg::StHalted;
        end else if (dec_pend == 2'd0) begin
            if (!d[7]) begin
                r.code_point = 21'(d);
                r.complete   = 1'b1;
            end else if (d[7:6] == 2'b10) begin
                bad = 1'b1;
            end else if (d[7:5] == 3'b110) begin
                bad  = (d <= 8'hC1);
                need = 2'd1;
                bits = 21'(d[4:0]);
            end else if (d[7:4] == 4'hE) begin
                need = 2'd2;
                bits = 21'(d[3:0]);
                rl   = (d == 8'hE0) ? u8vd_pkg::RuleE0 :
                       (d == 8'hED) ? u8vd_pkg::RuleEd : u8vd_pkg::RuleGeneric;
            end else if (d[7:2] == 6'b111100 || d == 8'hF4) begin
                need = 2'd3;
                bits = 21'(d[2:0]);
                rl   = (d == 8'hF0) ? u8vd_pkg::RuleF0 :
                       (d == 8'hF4) ? u8vd_pkg::RuleF4 : u8vd_pkg::RuleGeneric;
            end else begin
                bad = 1'b1;
            end
            if (bad) begin
                r.status = u8vd_pkg::StBadLead;
                drop_partial();
                dec_halted = 1'b1;
            end else if (need != 2'd0) begin
                // lead checked against what is left in the buffer, before any continuation
                if (b.bytes_after < need) begin
                    r.status = u8vd_pkg::StIncomplete;
                    drop_partial();
                    dec_halted = 1'b1;
                end else begin
                    dec_pend  = need;
                    dec_rule  = rl;
                    dec_first = 1'b1;
                    dec_acc   = bits;
                end
            end
        end else begin
            if (dec_first) begin
                case (dec_rule)
                    u8vd_pkg::RuleE0: ok = (d[7:5] == 3'b101);
                    u8vd_pkg::RuleEd: ok = (d[7:5] == 3'b100);
                    u8vd_pkg::RuleF0: ok = (d[7:5] == 3'b101) || (d[7:4] == 4'h9);
                    u8vd_pkg::RuleF4: ok = (d[7:4] == 4'h8);
                    default:          ok = (d[7:6] == 2'b10);
                endcase
            end else begin
                ok = (d[7:6] == 2'b10);
            end
            if (!ok) begin
                r.status = u8vd_pkg::StBadCont;
                drop_partial();
                dec_halted = 1'b1;
            end else begin
                dec_acc   = {dec_acc[14:0], d[5:0]};
                dec_first = 1'b0;
                dec_pend  = dec_pend - 2'd1;
                if (dec_pend == 2'd0) begin
                    r.code_point = dec_acc;
                    r.complete   = 1'b1;
                    drop_partial();
                end
            end
        end
        return r;
    endfunction

    task automatic push_beat(input logic [7:0] d, input logic [1:0] aft, input logic rs);
        u8vd_pkg::t_in b;
        b.data_byte   = d;
        b.bytes_after = aft;
        b.restart     = rs;
        byte_q.push_back(b);
    endtask

    function automatic logic [20:0] pick_cp(input int len);
        int lo;
        int hi;
        case (len)
            1:       begin lo = 'h0;     hi = 'h7F;     end
            2:       begin lo = 'h80;    hi = 'h7FF;    end
            3:       begin lo = 'h800;   hi = 'hFFFF;   end
            default: begin lo = 'h10000; hi = 'h10FFFF; end
        endcase
        if ($urandom_range(0, 3) == 0) return 21'($urandom_range(0, 1) ? lo : hi);
        return 21'($urandom_range(hi, lo));
    endfunction

    // flaw: 0 clean, 1 lead short of bytes, 2 one continuation replaced, 3 last byte dropped
    task automatic push_char(input logic [20:0] cp, input int len, input logic rs,
                             input int flaw);
        logic [7:0] enc [4];
        int         n;
        int         k;
        int         aft;
        enc[1] = {2'b10, cp[5:0]};
        enc[2] = {2'b10, cp[5:0]};
        enc[3] = {2'b10, cp[5:0]};
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
            end
        endcase
        n = len;
        if (len > 1) begin
            k = $urandom_range(1, len - 1);
            if (flaw == 2) enc[k] = 8'($urandom_range(0, 255));
            if (flaw == 3) n = len - 1;
        end
        if (flaw == 1 && len > 1) aft = $urandom_range(0, len - 2);
        else aft = len - 1 + $urandom_range(0, 3);
        push_beat(enc[0], 2'((aft > 3) ? 3 : aft), rs);
        for (int i = 1; i < n; i++) begin
            aft = $urandom_range(0, 1) ? (len - 1 - i) : $urandom_range(0, 3);
            push_beat(enc[i], 2'(aft), 1'b0);
        end
    endtask

    initial begin
        int   kind;
        int   len;
        int   flaw;
        logic broken;
        logic rs;

        // clean characters of every length and the narrowed first continuations
        push_beat(8'h00, 2'd3, 1'b1);
        push_beat(8'h7F, 2'd3, 1'b0);
        push_beat(8'hC2, 2'd1, 1'b0);
        push_beat(8'h80, 2'd0, 1'b0);
        push_beat(8'hEF, 2'd2, 1'b0);
        push_beat(8'hBF, 2'd1, 1'b0);
        push_beat(8'hBF, 2'd0, 1'b0);
        push_beat(8'hF0, 2'd3, 1'b0);
        push_beat(8'h90, 2'd2, 1'b0);
        push_beat(8'h80, 2'd1, 1'b0);
        push_beat(8'h80, 2'd0, 1'b0);
        push_beat(8'hF4, 2'd3, 1'b0);
        push_beat(8'h8F, 2'd0, 1'b0);
        push_beat(8'hBF, 2'd3, 1'b0);
        push_beat(8'hBF, 2'd2, 1'b0);
        // stray continuation as lead, then a halted byte
        push_beat(8'h80, 2'd3, 1'b0);
        push_beat(8'h41, 2'd3, 1'b0);
        // rejected leads and narrowed first continuations, each after a restart
        push_beat(8'hC1, 2'd3, 1'b1);
        push_beat(8'hF5, 2'd3, 1'b1);
        push_beat(8'hE0, 2'd3, 1'b1);
        push_beat(8'h80, 2'd2, 1'b0);
        push_beat(8'hED, 2'd3, 1'b1);
        push_beat(8'hA0, 2'd2, 1'b0);
        push_beat(8'hE1, 2'd1, 1'b1);
        push_beat(8'hFF, 2'd0, 1'b1);

        broken = 1'b1;
        while (byte_q.size() < 450) begin
            kind = $urandom_range(0, 99);
            rs   = broken || ($urandom_range(0, 19) == 0);
            if (kind < 82) begin
                len  = $urandom_range(1, 4);
                flaw = (kind < 68) ? 0 : $urandom_range(1, 3);
                push_char(pick_cp(len), len, rs, flaw);
                broken = (flaw != 0) && (len > 1);
            end else begin
                push_beat(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          ($urandom_range(0, 3) == 0));
                broken = 1'b1;
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (char_exp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin
        while (n_in_beats < 300) @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (60) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat_taken) begin
            if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                i_in_data  <= byte_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !out_hold && (calm || $urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        u8vd_pkg::t_out want;
        in_beat_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            char_exp_q.push_back(decode_byte(i_in_data));
            n_in_beats <= n_in_beats + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (char_exp_q.size() == 0) begin
                n_errors <= n_errors + 1;
                if (n_errors < 10)
                    $display("unexpected result beat: cp=%h complete=%b status=%0d",
                             o_out_data.code_point, o_out_data.complete,
                             o_out_data.status);
            end else begin
                want = char_exp_q.pop_front();
                if (o_out_data !== want) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display({"mismatch: cp exp %h got %h, complete exp %b got %b,",
                                  " status exp %0d got %0d"},
                                 want.code_point, o_out_data.code_point,
                                 want.complete, o_out_data.complete,
                                 want.status, o_out_data.status);
                end
            end
        end
    end

endmodule

>>> sim.f
design/u8vd_pkg.sv
design/u8vd_step.sv
design/utf8_validating_decoder.sv
design/u8vd_checker.sv
dv/tb_top.sv
